FILE: rtl/core/nearest_segment_search_macros.svh
// assertion macros for the nearest segment search block
`ifndef NEAREST_SEGMENT_SEARCH_MACROS_SVH
`define NEAREST_SEGMENT_SEARCH_MACROS_SVH

// condition holds in the same cycle
`define NSS_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("nss assertion failed");

// condition holds in the next cycle
`define NSS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("nss assertion failed");

`endif

FILE: rtl/core/nss_pkg.sv
// shared types and constants for the nearest segment search block
`default_nettype none

package nss_pkg;

    localparam int COORD_W = 16;
    localparam int NUM_W   = 49;
    localparam int DEN_W   = 33;
    localparam int QUO_W   = 16;
    localparam int DIST_W  = 33;

    // pipeline stage numbers of the search datapath
    localparam int ST_SEG  = 2;
    localparam int ST_KIND = 5;
    localparam int ST_NEG  = 6;
    localparam int ST_QUO  = ST_NEG + QUO_W;
    localparam int ST_FOOT = ST_QUO + 1;
    localparam int ST_DIFF = ST_FOOT + 1;
    localparam int ST_SQ   = ST_DIFF + 1;
    localparam int ST_DIST = ST_SQ + 1;

    typedef enum logic [1:0] {
        FOOT_BEGIN,
        FOOT_END,
        FOOT_DIV
    } foot_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN
    } back_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } seg_t;

    typedef struct packed {
        logic               query;
        logic [5:0]         slot;
        seg_t               seg;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef struct packed {
        logic       last;
        seg_t       seg;
        foot_kind_t kind;
        logic       negx;
        logic       negy;
    } side_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/nss_front.sv
// front end: accepts transactions, drops out-of-range loads, two-entry queue
`default_nettype none

module nss_front
    import nss_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [5:0]          slot,
    input  logic [COORD_W-1:0]  begin_x,
    input  logic [COORD_W-1:0]  begin_y,
    input  logic [COORD_W-1:0]  end_x,
    input  logic [COORD_W-1:0]  end_y,
    input  logic [COORD_W-1:0]  point_x,
    input  logic [COORD_W-1:0]  point_y,
    output head_t               head,
    input  logic                pop
);

    item_t      entry_reg [2];
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       accept;
    logic       push;
    item_t      item_c;

    always_comb
    begin
        item_c.query  = func;
        item_c.slot   = slot;
        item_c.seg.bx = begin_x;
        item_c.seg.by = begin_y;
        item_c.seg.ex = end_x;
        item_c.seg.ey = end_y;
        item_c.px     = point_x;
        item_c.py     = point_y;
    end

    assign in_stall   = (fill_reg == 2'd2);
    assign accept     = in_valid && !in_stall;
    // loads aimed past the table are taken and dropped
    assign push       = accept && (func || (int'(slot) < MAX_SEGMENTS));
    assign fill_next  = fill_reg + 2'(push) - 2'(pop);
    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_c;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nss_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module nss_div
    import nss_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - s;
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W:0]   trial;
        logic             fits;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign trial = (NUM_W + 1)'(den_in) << SH;
        assign fits  = ({1'b0, rem_in} >= trial);

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= fits ? (rem_in - trial[NUM_W-1:0]) : rem_in;
            den_reg[s] <= den_in;
            quo_reg[s] <= {quo_in[QUO_W-2:0], fits};
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/nss_back.sv
// back end: segment table, projection pipeline, minimum search, result register
`default_nettype none

module nss_back
    import nss_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  head_t               head,
    output logic                pop,
    input  logic [6:0]          segments_in_use,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [5:0]          best_segment,
    output logic [COORD_W-1:0]  foot_x,
    output logic [COORD_W-1:0]  foot_y,
    output logic [DIST_W-1:0]   offset_squared,
    output back_stat_t          stat
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    seg_t               mem [MAX_SEGMENTS];
    seg_t               mem_q_reg;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_clamped;
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;
    logic               issue;
    logic               issue_last;
    logic               load_we;
    logic               query_start;

    logic               valid_reg   [1:ST_DIST];
    side_t              side_reg    [1:ST_DIST];
    logic [IDX_W-1:0]   idx_pipe_reg [1:ST_DIST];
    side_t              side_in;

    logic signed [16:0] vx_reg, vy_reg, wx_reg, wy_reg;
    logic signed [33:0] wxvx_reg, wyvy_reg, vxx_reg, vyy_reg;
    logic signed [16:0] vx3_reg, vy3_reg, vx4_reg, vy4_reg;
    logic signed [34:0] c1_reg;
    logic [DEN_W-1:0]   c2_reg, c2_5_reg, den_reg;
    logic signed [51:0] nx_reg, ny_reg;
    foot_kind_t         kind_c;
    logic [NUM_W-1:0]   num_x_reg, num_y_reg;
    logic [QUO_W-1:0]   quo_x, quo_y;

    logic signed [17:0] qx_s, qy_s, div_x, div_y;
    logic [COORD_W-1:0] fx_c, fy_c;
    logic [COORD_W-1:0] fx_reg, fy_reg, fx24_reg, fy24_reg, fx25_reg, fy25_reg;
    logic [COORD_W-1:0] fx26_reg, fy26_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [33:0] dxx_reg, dyy_reg;
    logic [DIST_W-1:0]  dist_reg;

    logic [IDX_W-1:0]   best_idx_reg, cand_idx;
    logic [DIST_W-1:0]  best_d_reg, cand_d;
    logic [COORD_W-1:0] best_fx_reg, best_fy_reg, cand_fx, cand_fy;
    logic               take;
    logic               finish;

    logic               out_valid_reg;
    logic [5:0]         out_idx_reg;
    logic [COORD_W-1:0] out_fx_reg, out_fy_reg;
    logic [DIST_W-1:0]  out_d_reg;

    always_comb
    begin
        if (segments_in_use == 7'd0)
        begin
            count_clamped = CNT_W'(1);
        end
        else if (int'(segments_in_use) > MAX_SEGMENTS)
        begin
            count_clamped = CNT_W'(MAX_SEGMENTS);
        end
        else
        begin
            count_clamped = CNT_W'(segments_in_use);
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pop         = 1'b0;
        issue       = 1'b0;
        issue_last  = 1'b0;
        load_we     = 1'b0;
        query_start = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    if (!head.item.query)
                    begin
                        pop     = 1'b1;
                        load_we = 1'b1;
                    end
                    else if (!out_valid_reg)
                    begin
                        pop         = 1'b1;
                        query_start = 1'b1;
                        idx_next    = '0;
                        state_next  = BK_ISSUE;
                    end
                end
            end
            BK_ISSUE:
            begin
                issue      = 1'b1;
                issue_last = (CNT_W'(idx_reg) + CNT_W'(1) == count_reg);
                if (issue_last)
                begin
                    state_next = BK_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            BK_DRAIN:
            begin
                if (finish)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            count_reg <= count_clamped;
            px_reg    <= head.item.px;
            py_reg    <= head.item.py;
        end
    end

    // segment table
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[IDX_W'(head.item.slot)] <= head.item.seg;
        end
        if (issue)
        begin
            mem_q_reg <= mem[idx_reg];
        end
    end

    // side band that travels with each segment
    always_comb
    begin
        side_in      = '0;
        side_in.last = issue_last;
    end

    always_comb
    begin
        if (c1_reg <= 35'sd0)
        begin
            kind_c = FOOT_BEGIN;
        end
        else if ($signed({2'b00, c2_reg}) <= c1_reg)
        begin
            kind_c = FOOT_END;
        end
        else
        begin
            kind_c = FOOT_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= ST_DIST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[1] <= issue;
            for (int k = 2; k <= ST_DIST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[1]     <= side_in;
        idx_pipe_reg[1] <= idx_reg;
        for (int k = 2; k <= ST_DIST; k++)
        begin
            idx_pipe_reg[k]  <= idx_pipe_reg[k-1];
            side_reg[k].last <= side_reg[k-1].last;
            side_reg[k].seg  <= (k == ST_SEG) ? mem_q_reg : side_reg[k-1].seg;
            side_reg[k].kind <= (k == ST_KIND) ? kind_c : side_reg[k-1].kind;
            side_reg[k].negx <= (k == ST_NEG) ? nx_reg[51] : side_reg[k-1].negx;
            side_reg[k].negy <= (k == ST_NEG) ? ny_reg[51] : side_reg[k-1].negy;
        end
    end

    // projection datapath
    always_ff @(posedge clk)
    begin
        vx_reg <= 17'($signed(mem_q_reg.ex)) - 17'($signed(mem_q_reg.bx));
        vy_reg <= 17'($signed(mem_q_reg.ey)) - 17'($signed(mem_q_reg.by));
        wx_reg <= 17'($signed(px_reg)) - 17'($signed(mem_q_reg.bx));
        wy_reg <= 17'($signed(py_reg)) - 17'($signed(mem_q_reg.by));

        wxvx_reg <= wx_reg * vx_reg;
        wyvy_reg <= wy_reg * vy_reg;
        vxx_reg  <= vx_reg * vx_reg;
        vyy_reg  <= vy_reg * vy_reg;
        vx3_reg  <= vx_reg;
        vy3_reg  <= vy_reg;

        c1_reg  <= 35'(wxvx_reg) + 35'(wyvy_reg);
        c2_reg  <= DEN_W'(vxx_reg + vyy_reg);
        vx4_reg <= vx3_reg;
        vy4_reg <= vy3_reg;

        nx_reg   <= c1_reg * vx4_reg;
        ny_reg   <= c1_reg * vy4_reg;
        c2_5_reg <= c2_reg;

        num_x_reg <= nx_reg[51] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
        num_y_reg <= ny_reg[51] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
        den_reg   <= c2_5_reg;
    end

    nss_div u_div_x (
        .clk (clk),
        .num (num_x_reg),
        .den (den_reg),
        .quo (quo_x)
    );

    nss_div u_div_y (
        .clk (clk),
        .num (num_y_reg),
        .den (den_reg),
        .quo (quo_y)
    );

    always_comb
    begin
        qx_s  = side_reg[ST_QUO].negx ? -$signed({2'b00, quo_x}) : $signed({2'b00, quo_x});
        qy_s  = side_reg[ST_QUO].negy ? -$signed({2'b00, quo_y}) : $signed({2'b00, quo_y});
        div_x = 18'($signed(side_reg[ST_QUO].seg.bx)) + qx_s;
        div_y = 18'($signed(side_reg[ST_QUO].seg.by)) + qy_s;
        unique case (side_reg[ST_QUO].kind)
            FOOT_BEGIN:
            begin
                fx_c = side_reg[ST_QUO].seg.bx;
                fy_c = side_reg[ST_QUO].seg.by;
            end
            FOOT_END:
            begin
                fx_c = side_reg[ST_QUO].seg.ex;
                fy_c = side_reg[ST_QUO].seg.ey;
            end
            FOOT_DIV:
            begin
                fx_c = div_x[COORD_W-1:0];
                fy_c = div_y[COORD_W-1:0];
            end
            default:
            begin
                fx_c = side_reg[ST_QUO].seg.bx;
                fy_c = side_reg[ST_QUO].seg.by;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        fx_reg <= fx_c;
        fy_reg <= fy_c;

        dx_reg   <= 17'($signed(fx_reg)) - 17'($signed(px_reg));
        dy_reg   <= 17'($signed(fy_reg)) - 17'($signed(py_reg));
        fx24_reg <= fx_reg;
        fy24_reg <= fy_reg;

        dxx_reg  <= dx_reg * dx_reg;
        dyy_reg  <= dy_reg * dy_reg;
        fx25_reg <= fx24_reg;
        fy25_reg <= fy24_reg;

        dist_reg <= DIST_W'(dxx_reg + dyy_reg);
        fx26_reg <= fx25_reg;
        fy26_reg <= fy25_reg;
    end

    // running minimum, lowest index kept on ties
    assign take     = (idx_pipe_reg[ST_DIST] == '0) || (dist_reg < best_d_reg);
    assign cand_idx = take ? idx_pipe_reg[ST_DIST] : best_idx_reg;
    assign cand_d   = take ? dist_reg : best_d_reg;
    assign cand_fx  = take ? fx26_reg : best_fx_reg;
    assign cand_fy  = take ? fy26_reg : best_fy_reg;
    assign finish   = valid_reg[ST_DIST] && side_reg[ST_DIST].last;

    always_ff @(posedge clk)
    begin
        if (valid_reg[ST_DIST])
        begin
            best_idx_reg <= cand_idx;
            best_d_reg   <= cand_d;
            best_fx_reg  <= cand_fx;
            best_fy_reg  <= cand_fy;
        end
        if (finish)
        begin
            out_idx_reg <= 6'(cand_idx);
            out_fx_reg  <= cand_fx;
            out_fy_reg  <= cand_fy;
            out_d_reg   <= cand_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign best_segment   = out_idx_reg;
    assign foot_x         = out_fx_reg;
    assign foot_y         = out_fy_reg;
    assign offset_squared = out_d_reg;
    assign stat.busy      = (state_reg != BK_IDLE);
    assign stat.pop       = pop;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_segment_search.sv
// Nearest segment search: segment table, point query, nearest clamped projection.
//
// Input channel (in_valid / in_stall): a transaction with func 0 loads one segment
// into table entry slot; func 1 queries the point (point_x, point_y). Loads to a
// slot at or past MAX_SEGMENTS are taken and dropped.
// Output channel (out_valid / out_stall): one result per query, none per load.
// Config channel (cfg_valid / cfg_ready): writes segments_in_use; cfg_ready is
// always high. Write it only while the block is idle.
// A load is written to the table as the back end pops it. A query issues one
// table entry per cycle into a 26-stage projection pipeline built around a
// 16-stage divider. A queued query starts once the previous result is taken.
// Queries run one at a time; a two-entry input queue keeps taking transactions
// while a query runs or a result waits.
// When out_stall is high the result holds and the next query waits in the queue;
// the queue fills and in_stall rises.
// Reset empties the queue and pipeline and sets segments_in_use to 1. The table
// is not cleared: query only entries that were loaded.
`default_nettype none
`include "nearest_segment_search_macros.svh"

module nearest_segment_search
    import nss_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [6:0]                 cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [5:0]                 slot,
    input  logic signed [COORD_W-1:0]  begin_x,
    input  logic signed [COORD_W-1:0]  begin_y,
    input  logic signed [COORD_W-1:0]  end_x,
    input  logic signed [COORD_W-1:0]  end_y,
    input  logic signed [COORD_W-1:0]  point_x,
    input  logic signed [COORD_W-1:0]  point_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [5:0]                 best_segment,
    output logic signed [COORD_W-1:0]  foot_x,
    output logic signed [COORD_W-1:0]  foot_y,
    output logic [DIST_W-1:0]          offset_squared
);

    logic [6:0] segments_in_use_reg;
    head_t      head;
    logic       pop;
    back_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_in_use_reg <= 7'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            segments_in_use_reg <= cfg_data;
        end
    end

    nss_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .slot     (slot),
        .begin_x  (begin_x),
        .begin_y  (begin_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .point_x  (point_x),
        .point_y  (point_y),
        .head     (head),
        .pop      (pop)
    );

    nss_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .segments_in_use (segments_in_use_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .best_segment    (best_segment),
        .foot_x          (foot_x),
        .foot_y          (foot_y),
        .offset_squared  (offset_squared),
        .stat            (stat)
    );

    `NSS_ASSERT_SAME(a_pop_has_head, pop, head.valid)
    `NSS_ASSERT_SAME(a_query_needs_free_out, pop && head.item.query, !out_valid)
    `NSS_ASSERT_NEXT(a_result_from_query, !out_valid && !stat.busy, !out_valid)
    `NSS_ASSERT_SAME(a_pop_only_idle, stat.pop, !stat.busy)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the nearest segment search block
`timescale 1ns / 1ps

module tb_top;
    import nss_pkg::*;

    typedef struct {
        bit [5:0]           seg;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        bit [32:0]          sq_offset;
    } nearest_t;

    typedef struct {
        bit                 func;
        bit [5:0]           slot;
        logic signed [15:0] bx, by, ex, ey, px, py;
        bit                 typed;
        nearest_t           res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [6:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = 1'b0;
    logic [5:0] slot = '0;
    logic signed [15:0] begin_x = '0, begin_y = '0, end_x = '0, end_y = '0;
    logic signed [15:0] point_x = '0, point_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [5:0] best_segment;
    logic signed [15:0] foot_x, foot_y;
    logic [DIST_W-1:0] offset_squared;

    logic signed [15:0] tbl_bx[64], tbl_by[64], tbl_ex[64], tbl_ey[64];
    int unsigned search_count = 1;
    nearest_t pending_results[$];
    int unsigned idle_pct = 0, stall_pct = 0;
    int errors = 0, n_loads = 0, n_queries = 0, n_checked = 0;

    nearest_segment_search DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .slot(slot),
        .begin_x(begin_x), .begin_y(begin_y), .end_x(end_x), .end_y(end_y),
        .point_x(point_x), .point_y(point_y),
        .out_valid(out_valid), .out_stall(out_stall), .best_segment(best_segment),
        .foot_x(foot_x), .foot_y(foot_y), .offset_squared(offset_squared)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    function automatic nearest_t find_nearest(logic signed [15:0] qx, logic signed [15:0] qy);
        nearest_t r;
        longint px, py, bx, by, vx, vy, wx, wy, c1, c2, fx, fy, dx, dy, d, best_d;
        px = qx;
        py = qy;
        best_d = 0;
        r.seg = 0;
        r.fx = 0;
        r.fy = 0;
        for (int i = 0; i < search_count; i++)
        begin
            bx = tbl_bx[i];
            by = tbl_by[i];
            vx = longint'(tbl_ex[i]) - bx;
            vy = longint'(tbl_ey[i]) - by;
            wx = px - bx;
            wy = py - by;
            c1 = wx * vx + wy * vy;
            c2 = vx * vx + vy * vy;
            if (c1 <= 0)
            begin
                fx = bx;
                fy = by;
            end
            else if (c2 <= c1)
            begin
                fx = tbl_ex[i];
                fy = tbl_ey[i];
            end
            else
            begin
                fx = bx + (c1 * vx) / c2;
                fy = by + (c1 * vy) / c2;
            end
            dx = fx - px;
            dy = fy - py;
            d = dx * dx + dy * dy;
            if (i == 0 || d < best_d)
            begin
                best_d = d;
                r.seg = 6'(i);
                r.fx = 16'(fx);
                r.fy = 16'(fy);
            end
        end
        r.sq_offset = 33'(best_d);
        return r;
    endfunction

    // sender: optional idle gap, then hold the transaction until taken
    task automatic send_item(row_t r);
        nearest_t exp_r;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= r.func;
        slot <= r.slot;
        begin_x <= r.bx;
        begin_y <= r.by;
        end_x <= r.ex;
        end_y <= r.ey;
        point_x <= r.px;
        point_y <= r.py;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!r.func)
        begin
            tbl_bx[r.slot] = r.bx;
            tbl_by[r.slot] = r.by;
            tbl_ex[r.slot] = r.ex;
            tbl_ey[r.slot] = r.ey;
            n_loads++;
        end
        else
        begin
            exp_r = r.typed ? r.res : find_nearest(r.px, r.py);
            pending_results.push_back(exp_r);
            n_queries++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_count(bit [6:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        search_count = (v == 0) ? 1 : ((v > 64) ? 64 : v);
    endtask

    always @(posedge clk)
    begin
        nearest_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                n_checked++;
                if (best_segment !== e.seg)
                begin
                    $error("best_segment expected %0d actual %0d", e.seg, best_segment);
                    errors++;
                end
                if (foot_x !== e.fx)
                begin
                    $error("foot_x expected %0d actual %0d", e.fx, foot_x);
                    errors++;
                end
                if (foot_y !== e.fy)
                begin
                    $error("foot_y expected %0d actual %0d", e.fy, foot_y);
                    errors++;
                end
                if (offset_squared !== e.sq_offset)
                begin
                    $error("offset_squared expected %0d actual %0d", e.sq_offset,
                           offset_squared);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'($urandom_range(511)) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic row_t rand_load(bit [5:0] s);
        row_t r;
        int unsigned src;
        r = '{default: '0};
        r.slot = s;
        case ($urandom_range(9))
            0:
            begin
                src = $urandom_range(63);
                r.bx = tbl_bx[src];
                r.by = tbl_by[src];
                r.ex = tbl_ex[src];
                r.ey = tbl_ey[src];
            end
            1:
            begin
                r.bx = rand_coord();
                r.by = rand_coord();
                r.ex = r.bx;
                r.ey = r.by;
            end
            default:
            begin
                r.bx = rand_coord();
                r.by = rand_coord();
                r.ex = rand_coord();
                r.ey = rand_coord();
            end
        endcase
        return r;
    endfunction

    row_t directed[19] = '{
        '{0, 0, -32768, -32768, 32767, 32767, 0, 0, 0, '{0, 0, 0, 0}},
        '{1, 0, 0, 0, 0, 0, -32768, -32768, 1, '{0, -32768, -32768, 0}},
        '{1, 0, 0, 0, 0, 0, 32767, 32767, 1, '{0, 32767, 32767, 0}},
        '{1, 0, 0, 0, 0, 0, -32768, 32767, 0, '{0, 0, 0, 0}},
        '{1, 0, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
        '{0, 0, 100, 200, 100, 200, 0, 0, 0, '{0, 0, 0, 0}},
        '{1, 0, 0, 0, 0, 0, 100, 200, 1, '{0, 100, 200, 0}},
        '{0, 0, -32768, -32768, -32768, -32768, 0, 0, 0, '{0, 0, 0, 0}},
        '{1, 0, 0, 0, 0, 0, 32767, 32767, 1, '{0, -32768, -32768, 33'd8589672450}},
        '{0, 0, 32767, -32768, -32768, 32767, 0, 0, 0, '{0, 0, 0, 0}},
        '{1, 0, 0, 0, 0, 0, 32767, 32767, 0, '{0, 0, 0, 0}},
        '{1, 0, 0, 0, 0, 0, 32767, -32768, 1, '{0, 32767, -32768, 0}},
        '{0, 63, 0, 0, 16, 0, 0, 0, 0, '{0, 0, 0, 0}},
        '{1, 0, 0, 0, 0, 0, -1, -1, 0, '{0, 0, 0, 0}},
        '{0, 0, 0, 0, 160, 0, 0, 0, 0, '{0, 0, 0, 0}},
        '{1, 0, 0, 0, 0, 0, 80, 48, 1, '{0, 80, 0, 2304}},
        '{1, 0, 0, 0, 0, 0, -16, 5, 1, '{0, 0, 0, 281}},
        '{1, 0, 0, 0, 0, 0, 320, -7, 1, '{0, 160, 0, 25649}},
        '{0, 0, 0, 0, -3, -7, 0, 0, 0, '{0, 0, 0, 0}}
    };

    bit [6:0] phase_count[8] = '{64, 1, 127, 0, 7'd0, 7'd0, 32, 64};

    initial
    begin
        row_t r;
        for (int i = 0; i < 64; i++)
        begin
            tbl_bx[i] = 0;
            tbl_by[i] = 0;
            tbl_ex[i] = 0;
            tbl_ey[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i]);
        r = '{default: '0};
        r.func = 1;
        r.px = -1;
        r.py = -2;
        send_item(r);

        for (int s = 0; s < 64; s++)
            send_item(rand_load(s));

        phase_count[4] = $urandom_range(2, 63);
        phase_count[5] = $urandom_range(65, 127);
        for (int p = 0; p < 8; p++)
        begin
            write_count(phase_count[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            for (int n = 0; n < 200; n++)
            begin
                if (p == 2 && n == 100)
                    drain_results();
                if ($urandom_range(99) < 50)
                    r = rand_load($urandom_range(63));
                else
                begin
                    r = '{default: '0};
                    r.func = 1;
                    r.slot = 6'($urandom);
                    r.px = rand_coord();
                    r.py = rand_coord();
                end
                send_item(r);
            end
        end

        drain_results();
        stall_pct = 0;
        $display("covered %0d loads and %0d queries, %0d results checked", n_loads,
                 n_queries, n_checked);
        $display("search counts ran from one to a full table, with idle and stall mixes");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/nss_pkg.sv
rtl/core/nss_front.sv
rtl/core/nss_div.sv
rtl/core/nss_back.sv
rtl/core/nearest_segment_search.sv
tb/tb_top.sv
